// ===== hdl/prt_pkg.sv =====
// prt_pkg: shared types and codes for the pending request tracker
// beat payloads, command / result / register codes, cell-chain structs
// no dependencies
package prt_pkg;

	// width of the broadcast allocation count carried by the scan token
	localparam int DONE_W = 7;

	// input commands
	typedef enum logic [1:0] {
		CMD_SEND  = 2'd0,
		CMD_RESP  = 2'd1,
		CMD_TICK  = 2'd2,
		CMD_QUERY = 2'd3
	} cmd_t;

	// result kinds
	typedef enum logic [2:0] {
		KIND_SENT_OK        = 3'd0,
		KIND_REFUSED_UNSENT = 3'd1,
		KIND_REFUSED_SENT   = 3'd2,
		KIND_RESPONSE       = 3'd3,
		KIND_TIMEOUT        = 3'd4,
		KIND_REPLY          = 3'd5
	} kind_t;

	// configuration register indexes
	typedef enum logic [2:0] {
		REG_OWN_NODE_ID       = 3'd0,
		REG_TIMEOUT_TICKS     = 3'd1,
		REG_HARDWARE_REVISION = 3'd2,
		REG_SOFTWARE_REVISION = 3'd3,
		REG_ID_DISTRIBUTION   = 3'd4,
		REG_HEADER_TYPE       = 3'd5
	} cfg_reg_t;

	// operation run by the cell chain during one scan
	typedef enum logic [1:0] {
		OP_UNI  = 2'd0,
		OP_BC   = 2'd1,
		OP_RESP = 2'd2,
		OP_TICK = 2'd3
	} op_t;

	// input beat
	typedef struct packed {
		logic [1:0]  cmd;
		logic [7:0]  node_id;
		logic [7:0]  requester_tag;
		logic [63:0] now_time;
		logic        resp_is_four_bytes;
		logic [31:0] resp_data;
	} item_t;

	// result beat
	typedef struct packed {
		logic [2:0]  kind;
		logic [7:0]  peer_node;
		logic [7:0]  tag;
		logic [31:0] data;
		logic        last;
	} result_t;

	// configuration write beat
	typedef struct packed {
		logic [2:0]  index;
		logic [31:0] value;
	} cfg_wr_t;

	// scan token handed from cell to cell
	typedef struct packed {
		logic              want;
		logic [7:0]        next_id;
		logic [DONE_W-1:0] done;
	} scan_t;

	// controller broadcast to every cell
	typedef struct packed {
		logic        adv;
		op_t         op;
		logic [7:0]  node;
		logic [7:0]  tag;
		logic [7:0]  own_id;
		logic [63:0] deadline;
		logic [63:0] now;
	} cell_ctl_t;

	// per-cell report, zero unless the cell acts
	typedef struct packed {
		logic       hit;
		logic       alloc;
		logic [7:0] node;
		logic [7:0] tag;
	} cell_rpt_t;

endpackage

// ===== hdl/prt_chan_if.sv =====
// prt_chan_if: valid/ready channel carrying one payload per beat
// payload type is a parameter; no package dependency
interface prt_chan_if #(parameter type payload_t = logic);
	logic     valid;
	logic     ready;
	payload_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

// ===== hdl/prt_cell.sv =====
// prt_cell: one table entry of the tracker plus its scan token stage
// depends on prt_pkg
module prt_cell #(
	parameter int FOREIGN_NODES = 31
) (
	input  logic              clk,
	input  logic              arst_n,
	input  prt_pkg::cell_ctl_t ctl,
	input  logic              tok_in_v,
	input  prt_pkg::scan_t    tok_in,
	output logic              tok_out_v,
	output prt_pkg::scan_t    tok_out,
	output prt_pkg::cell_rpt_t rpt
);
	import prt_pkg::*;

	logic [7:0]  node_q;
	logic [7:0]  tag_q;
	logic [63:0] dl_q;
	logic        tok_v_q;
	scan_t       tok_q;

	logic        wr_en;
	logic        clr_en;
	logic [7:0]  wr_node;
	logic [7:0]  bc_id;

	// entry action while the token sits here
	always_comb begin
		tok_out = tok_q;
		wr_en   = 1'b0;
		clr_en  = 1'b0;
		wr_node = ctl.node;
		bc_id   = (tok_q.next_id == ctl.own_id) ? tok_q.next_id + 8'd1 : tok_q.next_id;
		if (tok_v_q) begin
			unique case (ctl.op)
				OP_UNI: begin
					if (tok_q.want && node_q == 8'd0) begin
						wr_en        = 1'b1;
						tok_out.want = 1'b0;
					end
				end
				OP_BC: begin
					if (node_q == 8'd0 && int'(tok_q.done) < FOREIGN_NODES) begin
						wr_en           = 1'b1;
						wr_node         = bc_id;
						tok_out.next_id = bc_id + 8'd1;
						tok_out.done    = tok_q.done + DONE_W'(1);
					end
				end
				OP_RESP: begin
					if (tok_q.want && node_q == ctl.node) begin
						clr_en       = 1'b1;
						tok_out.want = 1'b0;
					end
				end
				OP_TICK: begin
					if (node_q != 8'd0 && dl_q < ctl.now)
						clr_en = 1'b1;
				end
				default: ;
			endcase
		end
	end

	// report toward the controller
	always_comb begin
		rpt       = '0;
		rpt.alloc = wr_en;
		rpt.hit   = clr_en;
		if (clr_en) begin
			rpt.node = node_q;
			rpt.tag  = tag_q;
		end
	end

	assign tok_out_v = tok_v_q;

	// token stage and entry node, zero node means free
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_v_q <= 1'b0;
			node_q  <= 8'd0;
		end else if (ctl.adv) begin
			tok_v_q <= tok_in_v;
			if (wr_en)
				node_q <= wr_node;
			else if (clr_en)
				node_q <= 8'd0;
		end
	end

	// token payload and entry contents
	always_ff @(posedge clk) begin
		if (ctl.adv) begin
			tok_q <= tok_in;
			if (wr_en) begin
				tag_q <= ctl.tag;
				dl_q  <= ctl.deadline;
			end
		end
	end

endmodule

// ===== hdl/prt_ctrl.sv =====
// prt_ctrl: command sequencer, configuration registers and result staging
// depends on prt_pkg and prt_chan_if
module prt_ctrl #(
	parameter int TABLE_ENTRIES = 32,
	parameter int FOREIGN_NODES = 31
) (
	input  logic               clk,
	input  logic               arst_n,
	prt_chan_if.sink           item,
	prt_chan_if.source         result,
	prt_chan_if.sink           cfg,
	output prt_pkg::cell_ctl_t ctl,
	output logic               tok_v,
	output prt_pkg::scan_t     tok,
	input  logic               exit_v,
	input  prt_pkg::scan_t     exit_tok,
	input  prt_pkg::cell_rpt_t rpt
);
	import prt_pkg::*;

	localparam int FW = $clog2(TABLE_ENTRIES + 1);
	localparam bit SMALL_TBL = TABLE_ENTRIES < FOREIGN_NODES;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_FLUSH
	} state_t;

	state_t      state_q;
	op_t         op_q;
	logic [7:0]  node_q;
	logic [7:0]  tag_q;
	logic [63:0] now_q;
	logic [63:0] dl_q;
	logic [31:0] data_q;
	logic        pend_v_q;
	result_t     pend_q;
	logic        out_v_q;
	result_t     out_q;
	logic [FW-1:0] free_cnt_q;

	logic [7:0]  own_q;
	logic [31:0] timeout_q;
	logic [7:0]  hw_rev_q;
	logic [7:0]  sw_rev_q;
	logic [7:0]  id_dist_q;
	logic [7:0]  hdr_type_q;

	logic        out_free;
	logic        adv;
	logic        accept;
	logic        exit_now;
	logic        lau_v;
	op_t         lau_op;
	logic        dir_v;
	result_t     dir_res;
	result_t     hit_res;
	result_t     send_res;

	assign out_free = !out_v_q || result.ready;
	// the chain holds still when a second hit would find no room
	assign adv      = !(rpt.hit && pend_v_q && !out_free);
	assign item.ready = (state_q == ST_IDLE);
	assign accept   = item.valid && item.ready;
	assign exit_now = exit_v && adv;
	assign cfg.ready = 1'b1;

	assign result.valid   = out_v_q;
	assign result.payload = out_q;

	// decode of an accepted beat
	always_comb begin
		lau_v   = 1'b0;
		lau_op  = OP_TICK;
		dir_v   = 1'b0;
		dir_res = '0;
		dir_res.peer_node = item.payload.node_id;
		dir_res.tag       = item.payload.requester_tag;
		if (accept) begin
			unique case (cmd_t'(item.payload.cmd))
				CMD_SEND: begin
					if (item.payload.node_id == 8'd0) begin
						if (SMALL_TBL) begin
							dir_v        = 1'b1;
							dir_res.kind = KIND_REFUSED_UNSENT;
						end else if (int'(free_cnt_q) < FOREIGN_NODES) begin
							dir_v        = 1'b1;
							dir_res.kind = KIND_REFUSED_SENT;
						end else begin
							lau_v  = 1'b1;
							lau_op = OP_BC;
						end
					end else begin
						lau_v  = 1'b1;
						lau_op = OP_UNI;
					end
				end
				CMD_RESP: begin
					if (item.payload.resp_is_four_bytes && item.payload.node_id != 8'd0) begin
						lau_v  = 1'b1;
						lau_op = OP_RESP;
					end
				end
				CMD_TICK: begin
					lau_v  = 1'b1;
					lau_op = OP_TICK;
				end
				CMD_QUERY: begin
					dir_v        = 1'b1;
					dir_res.kind = KIND_REPLY;
					dir_res.tag  = 8'd0;
					dir_res.data = {hdr_type_q, id_dist_q, sw_rev_q, hw_rev_q};
				end
				default: ;
			endcase
		end
	end

	// token launched into the first cell
	assign tok_v       = lau_v;
	assign tok.want    = (lau_op != OP_BC);
	assign tok.next_id = 8'd1;
	assign tok.done    = '0;

	// broadcast to the cells
	assign ctl.adv      = adv;
	assign ctl.op       = op_q;
	assign ctl.node     = node_q;
	assign ctl.tag      = tag_q;
	assign ctl.own_id   = own_q;
	assign ctl.deadline = dl_q;
	assign ctl.now      = now_q;

	// result built from a cell hit or from the end of a send scan
	always_comb begin
		hit_res           = '0;
		hit_res.kind      = (op_q == OP_RESP) ? KIND_RESPONSE : KIND_TIMEOUT;
		hit_res.peer_node = rpt.node;
		hit_res.tag       = rpt.tag;
		hit_res.data      = (op_q == OP_RESP) ? data_q : 32'd0;
		send_res           = '0;
		send_res.kind      = exit_tok.want ? KIND_REFUSED_SENT : KIND_SENT_OK;
		send_res.peer_node = node_q;
		send_res.tag       = tag_q;
	end

	// sequencer, configuration and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			op_q       <= OP_TICK;
			node_q     <= 8'd0;
			tag_q      <= 8'd0;
			now_q      <= 64'd0;
			dl_q       <= 64'd0;
			data_q     <= 32'd0;
			pend_v_q   <= 1'b0;
			pend_q     <= '0;
			out_v_q    <= 1'b0;
			out_q      <= '0;
			free_cnt_q <= FW'(TABLE_ENTRIES);
			own_q      <= 8'd1;
			timeout_q  <= 32'd1000000;
			hw_rev_q   <= 8'd0;
			sw_rev_q   <= 8'd0;
			id_dist_q  <= 8'd0;
			hdr_type_q <= 8'd0;
		end else begin
			if (out_v_q && result.ready)
				out_v_q <= 1'b0;

			if (adv)
				free_cnt_q <= free_cnt_q + FW'(rpt.hit) - FW'(rpt.alloc);

			// register writes
			if (cfg.valid) begin
				unique case (cfg_reg_t'(cfg.payload.index))
					REG_OWN_NODE_ID:       own_q      <= cfg.payload.value[7:0];
					REG_TIMEOUT_TICKS:     timeout_q  <= cfg.payload.value;
					REG_HARDWARE_REVISION: hw_rev_q   <= cfg.payload.value[7:0];
					REG_SOFTWARE_REVISION: sw_rev_q   <= cfg.payload.value[7:0];
					REG_ID_DISTRIBUTION:   id_dist_q  <= cfg.payload.value[7:0];
					REG_HEADER_TYPE:       hdr_type_q <= cfg.payload.value[7:0];
					default: ;
				endcase
			end

			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						op_q   <= lau_op;
						node_q <= item.payload.node_id;
						tag_q  <= item.payload.requester_tag;
						now_q  <= item.payload.now_time;
						dl_q   <= item.payload.now_time + {32'd0, timeout_q};
						data_q <= item.payload.resp_data;
						if (dir_v) begin
							pend_q   <= dir_res;
							pend_v_q <= 1'b1;
							state_q  <= ST_FLUSH;
						end else if (lau_v) begin
							state_q <= ST_SCAN;
						end
					end
				end
				ST_SCAN: begin
					// hold the newest hit back so the final one can carry last
					if (adv && rpt.hit) begin
						if (pend_v_q) begin
							out_q      <= pend_q;
							out_q.last <= 1'b0;
							out_v_q    <= 1'b1;
						end
						pend_q   <= hit_res;
						pend_v_q <= 1'b1;
					end
					if (exit_now) begin
						if (op_q == OP_UNI || op_q == OP_BC) begin
							pend_q   <= send_res;
							pend_v_q <= 1'b1;
							state_q  <= ST_FLUSH;
						end else if (pend_v_q || rpt.hit) begin
							state_q <= ST_FLUSH;
						end else begin
							state_q <= ST_IDLE;
						end
					end
				end
				ST_FLUSH: begin
					if (out_free) begin
						out_q      <= pend_q;
						out_q.last <= 1'b1;
						out_v_q    <= 1'b1;
						pend_v_q   <= 1'b0;
						state_q    <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

// ===== hdl/pending_request_tracker.sv =====
// pending_request_tracker: one item at a time; a send, or a response or tick that
// yields results, walks a token down the cell chain one entry a cycle while no result
// stall holds the chain, then stages the final beat before the next item is taken
// a response or tick that yields no result goes back to idle when the token leaves
// query replies and refused broadcasts are staged directly, ignored responses give no beat
// arst_n clears every entry to free and loads register defaults at once, no sweep
module pending_request_tracker #(
	parameter int TABLE_ENTRIES = 32,
	parameter int FOREIGN_NODES = 31
) (
	input  logic       clk,
	input  logic       arst_n,
	prt_chan_if.sink   item,
	prt_chan_if.source result,
	prt_chan_if.sink   cfg
);
	import prt_pkg::*;

	cell_ctl_t ctl;
	logic      tok_v [TABLE_ENTRIES+1];
	scan_t     tok   [TABLE_ENTRIES+1];
	cell_rpt_t rpt_arr [TABLE_ENTRIES];
	cell_rpt_t rpt_or;

	// sequencer
	prt_ctrl #(
		.TABLE_ENTRIES (TABLE_ENTRIES),
		.FOREIGN_NODES (FOREIGN_NODES)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.item     (item),
		.result   (result),
		.cfg      (cfg),
		.ctl      (ctl),
		.tok_v    (tok_v[0]),
		.tok      (tok[0]),
		.exit_v   (tok_v[TABLE_ENTRIES]),
		.exit_tok (tok[TABLE_ENTRIES]),
		.rpt      (rpt_or)
	);

	// chain of table cells
	for (genvar i = 0; i < TABLE_ENTRIES; i++) begin : g_cell
		prt_cell #(
			.FOREIGN_NODES (FOREIGN_NODES)
		) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.ctl       (ctl),
			.tok_in_v  (tok_v[i]),
			.tok_in    (tok[i]),
			.tok_out_v (tok_v[i+1]),
			.tok_out   (tok[i+1]),
			.rpt       (rpt_arr[i])
		);
	end

	// only the cell holding the token reports, so an or merges them
	always_comb begin
		rpt_or = '0;
		for (int i = 0; i < TABLE_ENTRIES; i++)
			rpt_or = cell_rpt_t'(rpt_or | rpt_arr[i]);
	end

endmodule

// ===== tb/sv/tracker_result_checker.sv =====
// tracker_result_checker: watches the item, result and register channels of the
// pending request tracker, predicts every result beat and compares field by field
// depends on prt_pkg (beat structs, command / kind / register codes)
module tracker_result_checker #(
	parameter int TABLE_ENTRIES = 32,
	parameter int FOREIGN_NODES = 31
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              item_valid,
	input  logic              item_ready,
	input  prt_pkg::item_t    item_payload,
	input  logic              result_valid,
	input  logic              result_ready,
	input  prt_pkg::result_t  result_payload,
	input  logic              cfg_valid,
	input  logic              cfg_ready,
	input  prt_pkg::cfg_wr_t  cfg_payload,
	output int                fail_count,
	output int                outstanding,
	output int                beats_checked,
	output int                expiries_seen
);
	import prt_pkg::*;

	localparam int MAX_PRINTED = 40;

	// shadow of the request table and the registers
	logic [7:0]  slot_node     [TABLE_ENTRIES];
	logic [7:0]  slot_tag      [TABLE_ENTRIES];
	logic [63:0] slot_deadline [TABLE_ENTRIES];
	logic [7:0]  own_id;
	logic [31:0] timeout_us;
	logic [31:0] ident_word;

	// result beats still owed by the block, oldest first
	result_t pending_results[$];

	task automatic report_mismatch(input string what);
		fail_count++;
		if (fail_count <= MAX_PRINTED)
			$display("[%0t] result beat %0d: %s", $time, beats_checked, what);
	endtask

	task automatic restore_defaults();
		own_id = 8'd1;
		timeout_us = 32'd1000000;
		ident_word = 32'd0;
		foreach (slot_node[i]) begin
			slot_node[i] = 8'd0;
			slot_tag[i] = 8'd0;
			slot_deadline[i] = 64'd0;
		end
		pending_results.delete();
		fail_count = 0;
		beats_checked = 0;
		expiries_seen = 0;
	endtask

	task automatic write_register(input cfg_wr_t w);
		case (cfg_reg_t'(w.index))
			REG_OWN_NODE_ID:       own_id = w.value[7:0];
			REG_TIMEOUT_TICKS:     timeout_us = w.value;
			REG_HARDWARE_REVISION: ident_word[7:0] = w.value[7:0];
			REG_SOFTWARE_REVISION: ident_word[15:8] = w.value[7:0];
			REG_ID_DISTRIBUTION:   ident_word[23:16] = w.value[7:0];
			REG_HEADER_TYPE:       ident_word[31:24] = w.value[7:0];
			default: ;
		endcase
	endtask

	// allocate table entries for a send, returns the outcome kind
	function automatic kind_t place_request(input logic [7:0] node, input logic [7:0] tag,
			input logic [63:0] now);
		logic [63:0] deadline;
		logic [7:0]  next_id;
		int          free_slots;
		int          filled;
		deadline = now + 64'(timeout_us);
		if (node == 8'd0) begin
			if (TABLE_ENTRIES < FOREIGN_NODES)
				return KIND_REFUSED_UNSENT;
			free_slots = 0;
			foreach (slot_node[i])
				if (slot_node[i] == 8'd0)
					free_slots++;
			if (free_slots < FOREIGN_NODES)
				return KIND_REFUSED_SENT;
			// broadcast ids count up from 1, stepping over our own id once
			next_id = 8'd1;
			filled = 0;
			foreach (slot_node[i]) begin
				if (slot_node[i] == 8'd0 && filled < FOREIGN_NODES) begin
					if (next_id == own_id)
						next_id = next_id + 8'd1;
					slot_node[i] = next_id;
					slot_tag[i] = tag;
					slot_deadline[i] = deadline;
					filled++;
					next_id = next_id + 8'd1;
				end
			end
			return KIND_SENT_OK;
		end
		// unicast takes the first free entry
		foreach (slot_node[i]) begin
			if (slot_node[i] == 8'd0) begin
				slot_node[i] = node;
				slot_tag[i] = tag;
				slot_deadline[i] = deadline;
				return KIND_SENT_OK;
			end
		end
		return KIND_REFUSED_SENT;
	endfunction

	task automatic owe_result(input kind_t kind, input logic [7:0] peer,
			input logic [7:0] tag, input logic [31:0] data);
		result_t r;
		r.kind = kind;
		r.peer_node = peer;
		r.tag = tag;
		r.data = data;
		r.last = 1'b0;
		pending_results.push_back(r);
	endtask

	// work out the result beats of one accepted item beat
	task automatic predict_item(input item_t it);
		int      queued_before;
		bit      matched;
		result_t tail;
		queued_before = pending_results.size();
		matched = 1'b0;
		case (cmd_t'(it.cmd))
			CMD_SEND: begin
				owe_result(place_request(it.node_id, it.requester_tag, it.now_time),
					it.node_id, it.requester_tag, 32'd0);
			end
			CMD_RESP: begin
				// only four-byte responses from a real node can match
				if (it.resp_is_four_bytes && it.node_id != 8'd0) begin
					foreach (slot_node[i]) begin
						if (!matched && slot_node[i] == it.node_id) begin
							owe_result(KIND_RESPONSE, it.node_id, slot_tag[i], it.resp_data);
							slot_node[i] = 8'd0;
							slot_tag[i] = 8'd0;
							slot_deadline[i] = 64'd0;
							matched = 1'b1;
						end
					end
				end
			end
			CMD_TICK: begin
				// strictly past deadline expires
				foreach (slot_node[i]) begin
					if (slot_node[i] != 8'd0 && slot_deadline[i] < it.now_time) begin
						owe_result(KIND_TIMEOUT, slot_node[i], slot_tag[i], 32'd0);
						slot_node[i] = 8'd0;
						slot_tag[i] = 8'd0;
						slot_deadline[i] = 64'd0;
					end
				end
			end
			CMD_QUERY: begin
				owe_result(KIND_REPLY, it.node_id, 8'd0, ident_word);
			end
		endcase
		// mark the final beat of this item
		if (pending_results.size() > queued_before) begin
			tail = pending_results.pop_back();
			tail.last = 1'b1;
			pending_results.push_back(tail);
		end
	endtask

	task automatic check_result(input result_t got);
		result_t want;
		if (pending_results.size() == 0) begin
			report_mismatch($sformatf("nothing expected, got kind %0d node %0d tag %0d",
				got.kind, got.peer_node, got.tag));
			beats_checked++;
			return;
		end
		want = pending_results.pop_front();
		if (got.kind != want.kind)
			report_mismatch($sformatf("kind got %0d want %0d", got.kind, want.kind));
		if (got.peer_node != want.peer_node)
			report_mismatch($sformatf("peer_node got %0d want %0d",
				got.peer_node, want.peer_node));
		if (got.tag != want.tag)
			report_mismatch($sformatf("tag got %0d want %0d", got.tag, want.tag));
		if (got.data != want.data)
			report_mismatch($sformatf("data got %h want %h", got.data, want.data));
		if (got.last != want.last)
			report_mismatch($sformatf("last got %0d want %0d", got.last, want.last));
		if (want.kind == KIND_TIMEOUT)
			expiries_seen++;
		beats_checked++;
	endtask

	// result beats are checked before new items are predicted in the same cycle
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			restore_defaults();
			outstanding <= 0;
		end else begin
			if (result_valid && result_ready)
				check_result(result_payload);
			if (cfg_valid && cfg_ready)
				write_register(cfg_payload);
			if (item_valid && item_ready)
				predict_item(item_payload);
			outstanding <= pending_results.size();
		end
	end

endmodule

// ===== tb/sv/pending_request_tracker_tb.sv =====
// pending_request_tracker_tb: stimulus, clock, reset and verdict for the tracker
// depends on prt_pkg, prt_chan_if, pending_request_tracker and tracker_result_checker
module pending_request_tracker_tb;
	import prt_pkg::*;

	localparam int TABLE_ENTRIES   = 32;
	localparam int FOREIGN_NODES   = 31;
	localparam int SCAN_CYCLES     = TABLE_ENTRIES + 8;
	localparam int CYCLE_LIMIT     = 1000000;
	localparam int HOLD_OFF_CYCLES = 400;
	localparam int PHASES          = 5;
	localparam int PHASE_ROUNDS    = 60;

	logic clk;
	logic arst_n;

	prt_chan_if #(.payload_t(item_t))   item_ch ();
	prt_chan_if #(.payload_t(result_t)) result_ch ();
	prt_chan_if #(.payload_t(cfg_wr_t)) cfg_ch ();

	int fail_count;
	int outstanding;
	int beats_checked;
	int expiries_seen;

	// stimulus state shared with the result-side process
	bit          pace_gaps = 1'b1;
	bit          hold_request = 1'b0;
	int          items_offered = 0;
	int          cycle_count = 0;
	logic [63:0] clock_us;
	logic [31:0] timeout_cur;

	pending_request_tracker #(
		.TABLE_ENTRIES(TABLE_ENTRIES),
		.FOREIGN_NODES(FOREIGN_NODES)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.item(item_ch),
		.result(result_ch),
		.cfg(cfg_ch)
	);

	tracker_result_checker #(
		.TABLE_ENTRIES(TABLE_ENTRIES),
		.FOREIGN_NODES(FOREIGN_NODES)
	) u_checker (
		.clk(clk),
		.arst_n(arst_n),
		.item_valid(item_ch.valid),
		.item_ready(item_ch.ready),
		.item_payload(item_ch.payload),
		.result_valid(result_ch.valid),
		.result_ready(result_ch.ready),
		.result_payload(result_ch.payload),
		.cfg_valid(cfg_ch.valid),
		.cfg_ready(cfg_ch.ready),
		.cfg_payload(cfg_ch.payload),
		.fail_count(fail_count),
		.outstanding(outstanding),
		.beats_checked(beats_checked),
		.expiries_seen(expiries_seen)
	);

	// clock
	initial clk = 1'b0;
	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// watchdog
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("no progress after %0d cycles, %0d result beats owed",
				cycle_count, outstanding);
			$display("Regression FAIL");
			$finish;
		end
	end

	// result side: random stall bursts, one long hold-off on request
	initial begin
		result_ch.ready <= 1'b0;
		wait (arst_n);
		@(posedge clk);
		forever begin
			if (hold_request) begin
				hold_request = 1'b0;
				result_ch.ready <= 1'b0;
				for (int n = 0; n < HOLD_OFF_CYCLES; n++)
					@(posedge clk);
				result_ch.ready <= 1'b1;
				@(posedge clk);
			end else if (pace_gaps && $urandom_range(0, 4) == 0) begin
				result_ch.ready <= 1'b0;
				repeat ($urandom_range(1, 17)) @(posedge clk);
				result_ch.ready <= 1'b1;
				@(posedge clk);
			end else begin
				result_ch.ready <= 1'b1;
				@(posedge clk);
			end
		end
	end

	function automatic item_t compose_item(input cmd_t c, input logic [7:0] node,
			input logic [7:0] tag, input logic [63:0] now, input logic four,
			input logic [31:0] data);
		item_t it;
		it.cmd = c;
		it.node_id = node;
		it.requester_tag = tag;
		it.now_time = now;
		it.resp_is_four_bytes = four;
		it.resp_data = data;
		return it;
	endfunction

	// offer one item beat; valid stays high so the next beat can follow at once
	task automatic offer_item(input item_t it);
		if (pace_gaps && $urandom_range(0, 3) == 0) begin
			item_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 17)) @(posedge clk);
		end
		item_ch.payload <= it;
		item_ch.valid <= 1'b1;
		do @(posedge clk); while (!item_ch.ready);
		items_offered++;
	endtask

	// drop valid and wait until every owed beat is in and the scan has finished
	task automatic settle();
		item_ch.valid <= 1'b0;
		do @(posedge clk); while (outstanding != 0);
		repeat (SCAN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input cfg_reg_t idx, input logic [31:0] value);
		cfg_wr_t w;
		w.index = idx;
		w.value = value;
		cfg_ch.payload <= w;
		cfg_ch.valid <= 1'b1;
		do @(posedge clk); while (!cfg_ch.ready);
		cfg_ch.valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic configure(input logic [7:0] own, input logic [31:0] wait_us,
			input logic [31:0] ident);
		write_reg(REG_OWN_NODE_ID, 32'(own));
		write_reg(REG_TIMEOUT_TICKS, wait_us);
		write_reg(REG_HARDWARE_REVISION, 32'(ident[7:0]));
		write_reg(REG_SOFTWARE_REVISION, 32'(ident[15:8]));
		write_reg(REG_ID_DISTRIBUTION, 32'(ident[23:16]));
		write_reg(REG_HEADER_TYPE, 32'(ident[31:24]));
		timeout_cur = wait_us;
	endtask

	// jump far ahead so every entry expires, then broadcast into the empty table
	task automatic broadcast_round();
		clock_us = clock_us + 64'h4_0000_0000;
		offer_item(compose_item(CMD_TICK, 8'($urandom), 8'($urandom), clock_us,
			1'($urandom), $urandom));
		offer_item(compose_item(CMD_SEND, 8'd0, 8'($urandom), clock_us,
			1'($urandom), $urandom));
	endtask

	// mostly well-formed traffic on a small node pool, some broadcasts and noise
	task automatic random_round();
		int          pick;
		logic [7:0]  node;
		logic [63:0] step_us;
		cmd_t        c;
		pick = $urandom_range(0, 99);
		node = ($urandom_range(0, 6) == 0) ? 8'($urandom_range(1, 255)) :
			8'($urandom_range(1, 40));
		if (pick < 45) begin
			offer_item(compose_item(CMD_SEND, node, 8'($urandom), clock_us,
				1'($urandom), $urandom));
		end else if (pick < 65) begin
			offer_item(compose_item(CMD_RESP, node, 8'($urandom), clock_us,
				1'($urandom_range(0, 9) != 0), $urandom));
		end else if (pick < 80) begin
			step_us = 64'($urandom_range(0, 3)) * 64'(timeout_cur / 2) +
				64'($urandom_range(0, 50));
			clock_us = clock_us + step_us;
			offer_item(compose_item(CMD_TICK, node, 8'($urandom), clock_us,
				1'($urandom), $urandom));
		end else if (pick < 90) begin
			offer_item(compose_item(CMD_QUERY, 8'($urandom), 8'($urandom),
				{$urandom, $urandom}, 1'($urandom), $urandom));
		end else if (pick < 95) begin
			broadcast_round();
		end else begin
			c = cmd_t'($urandom_range(0, 3));
			offer_item(compose_item(c, 8'($urandom), 8'($urandom),
				(c == CMD_SEND) ? clock_us : {$urandom, $urandom},
				1'($urandom), $urandom));
		end
	endtask

	initial begin
		logic [7:0]  own_by_phase [PHASES];
		logic [31:0] wait_by_phase [PHASES];
		logic [31:0] ident;
		own_by_phase = '{8'd255, 8'd0, 8'd17, 8'd31, 8'd1};
		wait_by_phase = '{32'd0, 32'hFFFF_FFFF, 32'd1000000, 32'd5000, 32'd250};

		arst_n <= 1'b0;
		item_ch.valid <= 1'b0;
		item_ch.payload <= '0;
		cfg_ch.valid <= 1'b0;
		cfg_ch.payload <= '0;
		clock_us = 64'd1000;
		timeout_cur = 32'd1000000;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed part under reset register values
		offer_item(compose_item(CMD_QUERY, 8'd0, 8'd0, 64'd0, 1'b0, 32'd0));
		offer_item(compose_item(CMD_QUERY, 8'd255, 8'd255, '1, 1'b1, '1));
		// response with nothing pending, and from node zero
		offer_item(compose_item(CMD_RESP, 8'd0, 8'd0, 64'd0, 1'b1, '1));
		offer_item(compose_item(CMD_TICK, 8'd0, 8'd0, 64'd0, 1'b0, 32'd0));
		// deadline wraps past the top of the time range
		offer_item(compose_item(CMD_SEND, 8'd255, 8'd255, '1, 1'b0, 32'd0));
		offer_item(compose_item(CMD_SEND, 8'd7, 8'd0, 64'd0, 1'b0, 32'd0));
		// short response form is ignored, four-byte form matches once
		offer_item(compose_item(CMD_RESP, 8'd7, 8'd0, 64'd0, 1'b0, 32'd0));
		offer_item(compose_item(CMD_RESP, 8'd7, 8'd0, 64'd0, 1'b1, '1));
		offer_item(compose_item(CMD_RESP, 8'd7, 8'd0, 64'd0, 1'b1, '1));
		// deadline equal to now does not expire, one past it does
		offer_item(compose_item(CMD_TICK, 8'd0, 8'd0, 64'd999999, 1'b0, 32'd0));
		offer_item(compose_item(CMD_TICK, 8'd0, 8'd0, 64'd1000000, 1'b0, 32'd0));
		// broadcast fits beside one entry and fills the table
		offer_item(compose_item(CMD_SEND, 8'd40, 8'h5A, 64'd10, 1'b0, 32'd0));
		offer_item(compose_item(CMD_SEND, 8'd0, 8'hA5, 64'd20, 1'b0, 32'd0));
		// full table refuses unicast and broadcast
		offer_item(compose_item(CMD_SEND, 8'd9, 8'd1, 64'd30, 1'b0, 32'd0));
		offer_item(compose_item(CMD_SEND, 8'd0, 8'd2, 64'd30, 1'b0, 32'd0));
		// own id was skipped, so nothing answers for it
		offer_item(compose_item(CMD_RESP, 8'd1, 8'd0, 64'd30, 1'b1, 32'h1234_5678));
		offer_item(compose_item(CMD_RESP, 8'd32, 8'd0, 64'd30, 1'b1, 32'h1234_5678));
		offer_item(compose_item(CMD_SEND, 8'd32, 8'h77, 64'd40, 1'b0, 32'd0));
		offer_item(compose_item(CMD_RESP, 8'd32, 8'd0, 64'd40, 1'b1, 32'h8765_4321));
		// everything left expires in a single tick
		offer_item(compose_item(CMD_TICK, 8'd0, 8'd0, '1, 1'b0, 32'd0));
		offer_item(compose_item(CMD_QUERY, 8'd1, 8'd0, 64'd0, 1'b0, 32'd0));

		// random phases, each under its own register setting
		for (int p = 0; p < PHASES; p++) begin
			settle();
			case (p)
				0:       ident = 32'hFFFF_FFFF;
				1:       ident = 32'h0000_0000;
				default: ident = $urandom;
			endcase
			configure(own_by_phase[p], wait_by_phase[p], ident);
			pace_gaps = (p != PHASES - 1);
			if (p == 0) begin
				// zero timeout: deadline is the send time itself
				offer_item(compose_item(CMD_SEND, 8'd5, 8'd3, clock_us, 1'b0, 32'd0));
				offer_item(compose_item(CMD_TICK, 8'd0, 8'd0, clock_us, 1'b0, 32'd0));
				offer_item(compose_item(CMD_TICK, 8'd0, 8'd0, clock_us + 64'd1, 1'b0,
					32'd0));
			end
			// result side holds off while items keep coming
			if (p == 2)
				hold_request = 1'b1;
			broadcast_round();
			repeat (PHASE_ROUNDS) random_round();
		end
		settle();

		$display("%0d item beats over %0d register settings, %0d result beats checked",
			items_offered, PHASES + 1, beats_checked);
		$display("%0d timeouts, broadcasts into empty and full tables, one long result stall",
			expiries_seen);
		if (fail_count == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule

// ===== filelist.f =====
hdl/prt_pkg.sv
hdl/prt_chan_if.sv
hdl/prt_cell.sv
hdl/prt_ctrl.sv
hdl/pending_request_tracker.sv
tb/sv/tracker_result_checker.sv
tb/sv/pending_request_tracker_tb.sv
